[rtl/core/bpa_pkg.sv]
// Shared types and constants of the bitmap page allocator.
// No dependencies; every other file imports this package.
package bpa_pkg;

  localparam int unsigned WORD_W    = 32;  // map bits held in one memory word
  localparam int unsigned BIT_W     = 5;   // index of a bit inside a word
  localparam int unsigned CNT_W     = 11;  // page counts and free count
  localparam int unsigned ADDR_W    = 22;  // returned page address
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned PADDR_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // result of the shared limit-mask and first-free-bit unit
  typedef struct packed {
    logic              found;  // a free page lies in this word below the limit
    logic              last;   // limit ends within (or before) this word
    logic [BIT_W-1:0]  idx;    // lowest free bit
    logic [WORD_W-1:0] mask;   // bits whose page is below the limit
  } scan_res_t;

endpackage

[rtl/core/bpa_if.sv]
// Channel interfaces of the bitmap page allocator: request, response, config.
// Depends on bpa_pkg.
interface bpa_req_if import bpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [PADDR_W-1:0] page_address;

  modport source (output valid, func, page_address, input ready);
  modport sink   (input valid, func, page_address, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] alloc_address;
  logic [1:0]        status;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, alloc_address, status, free_count, input ready);
  modport sink   (input valid, alloc_address, status, free_count, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/bitmap_page_allocator.sv]
// Bitmap page allocator top: sequencer, counters and response register; needs bpa_pkg, bpa_if.
// Init writes each map word in turn; allocate reads words in order up to a hit or the limit;
// free reads the addressed word and clears the page's bit if set; others go straight to the result.
// One transaction at a time: the next is taken in the cycle after the result register loads, and
// a stalled result holds the sequencer. The map is swept one 32-bit word a cycle.
// Reset clears control state and the free count; the map reads as zero until first init.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o,
  bpa_cfg_if.sink   cfg_i
);

  localparam int unsigned NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INIT     = 3'd1;
  localparam logic [2:0] S_ALC_RD   = 3'd2;
  localparam logic [2:0] S_ALC_SCAN = 3'd3;
  localparam logic [2:0] S_FREE_RD  = 3'd4;
  localparam logic [2:0] S_FREE_CHK = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [WADDR_W-1:0] wptr_q, wptr_d;
  logic [WADDR_W-1:0] chk_q, chk_d;
  logic [WADDR_W-1:0] fword_q, fword_d;
  logic [BIT_W-1:0]   fbit_q, fbit_d;
  logic [CNT_W-1:0]   lim_q, lim_d;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  status_e            res_st_q, res_st_d;
  logic [CNT_W-1:0]   page_cnt_q;
  logic [CNT_W-1:0]   reserved_q;

  logic               rsp_vld_q;
  logic [ADDR_W-1:0]  rsp_addr_q;
  status_e            rsp_st_q;
  logic [CNT_W-1:0]   rsp_cnt_q;
  logic               rsp_load;

  logic [CNT_W-1:0]   n_eff, r_eff;
  logic [PADDR_W-1:0] req_page;
  logic               req_fire;

  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic [WADDR_W-1:0] scan_word;
  logic [CNT_W-1:0]   scan_lim;
  scan_res_t          scan;
  logic [63:0]        alloc_full;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q <= CNT_W'(1024);
      reserved_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_PAGE_COUNT: page_cnt_q <= cfg_i.data;
        CFG_RESERVED:   reserved_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign n_eff = ({21'd0, page_cnt_q} > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_cnt_q;
  assign r_eff = (reserved_q > n_eff) ? n_eff : reserved_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_page    = req_i.page_address >> PAGE_SHIFT;

  // shared scan unit: init mask generation and allocate search
  assign scan_word = (state_q == S_INIT) ? wptr_q : chk_q;
  assign scan_lim  = (state_q == S_INIT) ? lim_q : n_eff;

  bpa_scan #(.AW(WADDR_W)) u_scan (
    .word_addr_i (scan_word),
    .limit_i     (scan_lim),
    .word_i      (rd_data),
    .res_o       (scan)
  );

  bpa_map #(.DEPTH(NUM_WORDS), .AW(WADDR_W)) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign alloc_full = 64'({chk_q, scan.idx}) << PAGE_SHIFT;

  always_comb begin
    state_d    = state_q;
    wptr_d     = wptr_q;
    chk_d      = chk_q;
    fword_d    = fword_q;
    fbit_d     = fbit_q;
    lim_d      = lim_q;
    free_cnt_d = free_cnt_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    rd_en      = 1'b0;
    rd_addr    = wptr_q;
    wr_en      = 1'b0;
    wr_addr    = wptr_q;
    wr_data    = scan.mask;
    rsp_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_addr_d = '0;
          res_st_d   = ST_OK;
          wptr_d     = '0;
          chk_d      = '0;
          case (req_i.func)
            FN_INIT: begin
              lim_d      = r_eff;
              free_cnt_d = n_eff - r_eff;
              state_d    = S_INIT;
            end
            FN_ALLOC: begin
              if (free_cnt_q == '0) begin
                res_st_d = ST_NONE;
                state_d  = S_RESP;
              end else begin
                state_d = S_ALC_RD;
              end
            end
            FN_FREE: begin
              fword_d = req_page[WADDR_W+BIT_W-1:BIT_W];
              fbit_d  = req_page[BIT_W-1:0];
              if (req_page < 32'(n_eff)) begin
                state_d = S_FREE_RD;
              end else begin
                res_st_d = ST_IGNORED;
                state_d  = S_RESP;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_INIT: begin
        wr_en = 1'b1;
        if (wptr_q == WADDR_W'(NUM_WORDS - 1)) begin
          state_d = S_RESP;
        end else begin
          wptr_d = wptr_q + 1'b1;
        end
      end
      S_ALC_RD: begin
        rd_en   = 1'b1;
        wptr_d  = wptr_q + 1'b1;
        state_d = S_ALC_SCAN;
      end
      S_ALC_SCAN: begin
        // read of the next word overlaps the check of the current one
        rd_en  = 1'b1;
        wptr_d = wptr_q + 1'b1;
        if (scan.found) begin
          wr_en      = 1'b1;
          wr_addr    = chk_q;
          wr_data    = rd_data | (WORD_W'(1) << scan.idx);
          free_cnt_d = free_cnt_q - 1'b1;
          res_addr_d = alloc_full[ADDR_W-1:0];
          state_d    = S_RESP;
        end else if (scan.last) begin
          res_st_d = ST_NONE;
          state_d  = S_RESP;
        end else begin
          chk_d = chk_q + 1'b1;
        end
      end
      S_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = fword_q;
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        wr_addr = fword_q;
        wr_data = rd_data & ~(WORD_W'(1) << fbit_q);
        if (rd_data[fbit_q]) begin
          wr_en = 1'b1;
          if (free_cnt_q != COUNT_MAX) begin
            free_cnt_d = free_cnt_q + 1'b1;
          end
        end else begin
          res_st_d = ST_IGNORED;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wptr_q     <= '0;
      chk_q      <= '0;
      free_cnt_q <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wptr_q     <= wptr_d;
      chk_q      <= chk_d;
      free_cnt_q <= free_cnt_d;
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fword_q    <= fword_d;
    fbit_q     <= fbit_d;
    lim_q      <= lim_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (rsp_load) begin
      rsp_addr_q <= res_addr_q;
      rsp_st_q   <= res_st_q;
      rsp_cnt_q  <= free_cnt_q;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.alloc_address = rsp_addr_q;
  assign rsp_o.status        = rsp_st_q;
  assign rsp_o.free_count    = rsp_cnt_q;

  // allocate with an empty count goes straight to the response with no page
  a_alloc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.func == FN_ALLOC && free_cnt_q == '0)
      |=> (state_q == S_RESP && res_st_q == ST_NONE))
    else $error("allocate on empty count did not report no free page");

  // a page found by the search costs exactly one from the free count
  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALC_SCAN && scan.found)
      |=> (free_cnt_q == $past(free_cnt_q) - 1'b1))
    else $error("free count not decremented on allocate");

  // the map is never written while idle or holding a result
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP) |-> !wr_en)
    else $error("map written outside an operation");

endmodule

[rtl/core/bpa_map.sv]
// Used-bit map memory: one write and one registered read port.
// Reads as all zero until the first write (first init). Depends on bpa_pkg.
module bpa_map import bpa_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              written_q;
  logic              rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= written_q;
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

[rtl/core/bpa_scan.sv]
// Shared limit-mask and lowest-free-bit unit, used by init and allocate.
// Depends on bpa_pkg.
module bpa_scan import bpa_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic [AW-1:0]     word_addr_i,
  input  logic [CNT_W-1:0]  limit_i,
  input  logic [WORD_W-1:0] word_i,
  output scan_res_t         res_o
);

  localparam int unsigned BW = AW + BIT_W;
  localparam int unsigned CW = ((BW > CNT_W) ? BW : CNT_W) + 1;

  logic [CW-1:0]     base;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     diff;
  logic [WORD_W-1:0] free_bits;

  assign base = CW'({word_addr_i, {BIT_W{1'b0}}});
  assign lim  = CW'(limit_i);
  assign diff = lim - base;

  always_comb begin
    res_o = '0;
    if (lim <= base) begin
      res_o.mask = '0;
      res_o.last = 1'b1;
    end else if (diff >= CW'(WORD_W)) begin
      res_o.mask = '1;
      res_o.last = (diff == CW'(WORD_W));
    end else begin
      res_o.mask = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
      res_o.last = 1'b1;
    end
    free_bits   = res_o.mask & ~word_i;
    res_o.found = |free_bits;
    // downward walk so the lowest free bit wins
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        res_o.idx = BIT_W'(b);
      end
    end
  end

endmodule
